// ===== src/nau_pkg.sv =====
// ----------------------------------------------------------------------------
// nau_pkg
// Shared widths, codes, stage words and rounding helper for the activation
// unit.
// ----------------------------------------------------------------------------
package nau_pkg;

    localparam int NAU_FRAC_BITS     = 12;
    localparam int NAU_TABLE_ENTRIES = 256;
    localparam int NAU_DATA_W        = 16;
    localparam int NAU_ONE           = 1 << NAU_FRAC_BITS;
    localparam int NAU_MAG_W         = NAU_FRAC_BITS + 3;
    localparam int NAU_OPND_W        = NAU_DATA_W + 1;
    localparam int NAU_PROD_W        = 2 * NAU_OPND_W;
    localparam int NAU_SIDE_W        = 20;
    localparam int NAU_T_W           = NAU_FRAC_BITS + 1;
    localparam int NAU_RS_W          = 40;
    localparam int NAU_LEAK_NUM      = 41;
    localparam int NAU_LEAK_SHIFT    = 12;
    localparam int NAU_LEAK_ONE      =
        (NAU_ONE * NAU_LEAK_NUM + (1 << (NAU_LEAK_SHIFT - 1))) >> NAU_LEAK_SHIFT;

    localparam int NAU_ADDR_W  = 3;
    localparam int NAU_PDATA_W = 32;
    localparam int NAU_MODE_W  = 2;

    localparam logic [0:0] NAU_REG_MODE = 1'b0;

    localparam logic ACT_FORWARD = 1'b0;
    localparam logic ACT_DERIV   = 1'b1;

    typedef enum logic [NAU_MODE_W-1:0] {
        MODE_SIGMOID = 2'd0,
        MODE_RELU    = 2'd1,
        MODE_TANH    = 2'd2
    } mode_t;

    typedef struct packed {
        logic                         action;
        logic                         last;
        logic                         neg;
        logic                         above;
        logic                         sat;
        logic signed [NAU_DATA_W-1:0] x;
        logic [NAU_MAG_W-1:0]         mag;
        logic signed [NAU_PROD_W-1:0] prod;
    } front_t;

    typedef struct packed {
        logic                         action;
        logic                         last;
        logic                         neg;
        logic [NAU_T_W-1:0]           t;
        logic signed [NAU_SIDE_W-1:0] side;
    } mid_t;

    // round half away from zero
    function automatic logic signed [NAU_RS_W-1:0] round_shift(
        input logic signed [NAU_RS_W-1:0] p,
        input int unsigned                sh
    );
        logic [NAU_RS_W-1:0] m;
        m = p[NAU_RS_W-1] ? NAU_RS_W'(-p) : NAU_RS_W'(p);
        m = (m + (NAU_RS_W'(1) << (sh - 1))) >> sh;
        return p[NAU_RS_W-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ===== src/neural_activation_unit.sv =====
// ----------------------------------------------------------------------------
// neural_activation_unit
// Elementwise sigmoid, clipped leaky ReLU or leaky tanh on Q4.12 samples,
// forward value or derivative, with an APB mode register.
// ----------------------------------------------------------------------------
//  channel   handshake                  fields
//  sample    sample_valid/sample_ready  action, value, last
//  result    result_valid/result_ready  result, last_out
//  config    APB write/read             mode at byte address 0
//
//  One word per cycle sustained when the output is not stalled; five
//  register stages: front, ROM read, slope multiply, interpolation, output.
//  Reset clears all stage valid bits and sets mode to sigmoid.
//  A stalled result holds its stage; earlier stages keep filling bubbles.
// ----------------------------------------------------------------------------
module neural_activation_unit #(
    parameter int TABLE_ENTRIES = nau_pkg::NAU_TABLE_ENTRIES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [nau_pkg::NAU_ADDR_W-1:0]        paddr,
    input  logic [nau_pkg::NAU_PDATA_W-1:0]       pwdata,
    output logic [nau_pkg::NAU_PDATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic                                  action,
    input  logic signed [nau_pkg::NAU_DATA_W-1:0] value,
    input  logic                                  last,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [nau_pkg::NAU_DATA_W-1:0] result,
    output logic                                  last_out
);
    import nau_pkg::*;

    logic [NAU_MODE_W-1:0] mode_reg, mode_next;
    logic                  mode_sel;
    logic                  front_valid;
    logic                  front_ready;
    front_t                front;
    logic                  mid_valid;
    logic                  mid_ready;
    mid_t                  mid;

    assign pready   = 1'b1;
    assign mode_sel = paddr[NAU_ADDR_W-1:2] == NAU_REG_MODE;
    assign mode_next = (psel && penable && pwrite && pready && mode_sel) ?
                       pwdata[NAU_MODE_W-1:0] : mode_reg;
    assign prdata   = mode_sel ? NAU_PDATA_W'(mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_SIGMOID;
        else
            mode_reg <= mode_next;
    end

    nau_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .action       (action),
        .value        (value),
        .last         (last),
        .front_valid  (front_valid),
        .front_ready  (front_ready),
        .front        (front)
    );

    nau_interp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_interp (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode_reg),
        .front_valid (front_valid),
        .front_ready (front_ready),
        .front       (front),
        .mid_valid   (mid_valid),
        .mid_ready   (mid_ready),
        .mid         (mid)
    );

    nau_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .mid_valid    (mid_valid),
        .mid_ready    (mid_ready),
        .mid          (mid),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .last_out     (last_out)
    );

endmodule

// ===== src/nau_front.sv =====
// ----------------------------------------------------------------------------
// nau_front
// First stage: magnitude, table position flags and the shared product for
// the derivative and leaky ReLU paths.
// ----------------------------------------------------------------------------
module nau_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [nau_pkg::NAU_MODE_W-1:0]      mode,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic                                action,
    input  logic signed [nau_pkg::NAU_DATA_W-1:0] value,
    input  logic                                last,
    output logic                                front_valid,
    input  logic                                front_ready,
    output nau_pkg::front_t                     front
);
    import nau_pkg::*;

    localparam logic signed [NAU_OPND_W-1:0] ONE_EXT  = NAU_OPND_W'(NAU_ONE);
    localparam logic signed [NAU_OPND_W-1:0] LEAK_EXT = NAU_OPND_W'(NAU_LEAK_NUM);
    localparam logic [NAU_DATA_W:0]          SAT_LIM  = (NAU_DATA_W + 1)'(8 * NAU_ONE);

    logic                          valid_reg;
    logic                          valid_next;
    logic                          en;
    front_t                        front_reg;
    front_t                        front_next;
    logic signed [NAU_OPND_W-1:0]  x_ext;
    logic signed [NAU_OPND_W-1:0]  neg_x;
    logic signed [NAU_OPND_W-1:0]  opnd_a;
    logic signed [NAU_OPND_W-1:0]  opnd_b;
    logic [NAU_DATA_W-1:0]         mag_full;

    assign en           = !valid_reg || front_ready;
    assign sample_ready = en;
    assign valid_next   = en ? sample_valid : valid_reg;
    assign front_valid  = valid_reg;
    assign front        = front_reg;

    always_comb
    begin
        x_ext    = {value[NAU_DATA_W-1], value};
        neg_x    = -x_ext;
        mag_full = value[NAU_DATA_W-1] ? neg_x[NAU_DATA_W-1:0] : value;
        opnd_a   = x_ext;
        opnd_b   = '0;
        if (action == ACT_DERIV)
        begin
            unique case (mode)
                MODE_SIGMOID: opnd_b = ONE_EXT - x_ext;
                MODE_TANH:    opnd_b = x_ext;
                default:      opnd_b = '0;
            endcase
        end
        else if (mode == MODE_RELU)
        begin
            opnd_a = value[NAU_DATA_W-1] ? x_ext : x_ext - ONE_EXT;
            opnd_b = LEAK_EXT;
        end
        front_next.action = action;
        front_next.last   = last;
        front_next.neg    = value[NAU_DATA_W-1];
        front_next.above  = x_ext > ONE_EXT;
        front_next.sat    = {1'b0, mag_full} >= SAT_LIM;
        front_next.x      = value;
        front_next.mag    = mag_full[NAU_MAG_W-1:0];
        front_next.prod   = opnd_a * opnd_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

endmodule

// ===== src/nau_interp.sv =====
// ----------------------------------------------------------------------------
// nau_interp
// Table stages: ROM read of the two bracketing entries, slope product and
// interpolation with rounding; the non-table result rides alongside.
// ----------------------------------------------------------------------------
module nau_interp #(
    parameter int TABLE_ENTRIES = nau_pkg::NAU_TABLE_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [nau_pkg::NAU_MODE_W-1:0] mode,
    input  logic                           front_valid,
    output logic                           front_ready,
    input  nau_pkg::front_t                front,
    output logic                           mid_valid,
    input  logic                           mid_ready,
    output nau_pkg::mid_t                  mid
);
    import nau_pkg::*;

    localparam int ADDR_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int FRAC_W  = NAU_MAG_W;
    localparam int P_W     = FRAC_W + ADDR_W;
    localparam int ENT_W   = 32;
    localparam int DIFF_W  = 31;
    localparam int IPROD_W = DIFF_W + FRAC_W;
    localparam int RND_SH  = 30 - NAU_FRAC_BITS;
    localparam logic [63:0] Q30 = 64'd1 << 30;

    typedef logic [TABLE_ENTRIES:0][ENT_W-1:0] rom_t;

    typedef struct packed {
        logic                         action;
        logic                         last;
        logic                         neg;
        logic                         sat;
        logic signed [NAU_SIDE_W-1:0] side;
    } carry_t;

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (Q30 >> 1)) >> 30;
    endfunction

    // bitwise long division for the table build
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        int          b;
        r = '0;
        q = '0;
        for (b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-t by Taylor series at t/256, then eight squarings
    function automatic rom_t build_rom(input logic want_tanh);
        rom_t        rom;
        logic [63:0] y;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] e2;
        logic [63:0] den;
        int          k;
        int          i;
        for (k = 0; k <= TABLE_ENTRIES; k++)
        begin
            y    = udiv(64'(k) << 25, 64'(TABLE_ENTRIES));
            sum  = Q30;
            term = q30_mul(Q30, y);
            sum  = sum - term;
            term = udiv(q30_mul(term, y), 64'd2);
            sum  = sum + term;
            term = udiv(q30_mul(term, y), 64'd3);
            sum  = sum - term;
            term = udiv(q30_mul(term, y), 64'd4);
            sum  = sum + term;
            term = udiv(q30_mul(term, y), 64'd5);
            sum  = sum - term;
            term = udiv(q30_mul(term, y), 64'd6);
            sum  = sum + term;
            e    = sum;
            for (i = 0; i < 8; i++)
                e = q30_mul(e, e);
            e2 = q30_mul(e, e);
            if (want_tanh)
            begin
                den    = Q30 + e2;
                rom[k] = ENT_W'(udiv((Q30 - e2) << 30, den));
            end
            else
            begin
                den    = Q30 + e;
                rom[k] = ENT_W'(udiv((64'd1 << 60) + (den >> 1), den));
            end
        end
        return rom;
    endfunction

    localparam rom_t SIG_ROM  = build_rom(1'b0);
    localparam rom_t TANH_ROM = build_rom(1'b1);

    logic                          en2;
    logic                          en3;
    logic                          en4;
    logic                          v2_reg, v2_next;
    logic                          v3_reg, v3_next;
    logic                          v4_reg, v4_next;

    logic [P_W-1:0]                pos;
    logic [ADDR_W-1:0]             idx;
    logic [ADDR_W-1:0]             idx_hi;
    logic signed [NAU_RS_W-1:0]    rs_f;
    logic signed [NAU_RS_W-1:0]    rs_l;
    logic signed [NAU_RS_W-1:0]    side_full;
    carry_t                        c2_reg, c2_next;
    logic [FRAC_W-1:0]             f2_reg, f2_next;
    logic [ENT_W-1:0]              lo2_reg;
    logic [ENT_W-1:0]              hi2_reg;

    logic [ENT_W-1:0]              diff_full;
    logic [DIFF_W-1:0]             diff;
    carry_t                        c3_reg;
    logic [ENT_W-1:0]              lo3_reg;
    logic                          down3_reg, down3_next;
    logic [IPROD_W-1:0]            iprod3_reg, iprod3_next;

    logic [DIFF_W-1:0]             step;
    logic [ENT_W-1:0]              val;
    logic [ENT_W:0]                rsum;
    mid_t                          mid_reg, mid_next;

    assign en4         = !v4_reg || mid_ready;
    assign en3         = !v3_reg || en4;
    assign en2         = !v2_reg || en3;
    assign front_ready = en2;
    assign v2_next     = en2 ? front_valid : v2_reg;
    assign v3_next     = en3 ? v2_reg : v3_reg;
    assign v4_next     = en4 ? v3_reg : v4_reg;
    assign mid_valid   = v4_reg;
    assign mid         = mid_reg;

    assign pos    = P_W'(front.mag) * P_W'(TABLE_ENTRIES);
    assign idx    = pos[P_W-1:FRAC_W];
    assign idx_hi = idx + ADDR_W'(1);

    always_comb
    begin
        rs_f      = round_shift(NAU_RS_W'(front.prod), NAU_FRAC_BITS);
        rs_l      = round_shift(NAU_RS_W'(front.prod), NAU_LEAK_SHIFT);
        side_full = '0;
        if (front.action == ACT_DERIV)
        begin
            unique case (mode)
                MODE_SIGMOID: side_full = rs_f;
                MODE_TANH:    side_full = NAU_RS_W'(NAU_ONE) - rs_f;
                MODE_RELU:    side_full = (front.neg || front.above) ?
                                          NAU_RS_W'(NAU_LEAK_ONE) : NAU_RS_W'(NAU_ONE);
                default:      side_full = '0;
            endcase
        end
        else if (mode == MODE_RELU)
        begin
            if (front.neg)
                side_full = rs_l;
            else if (front.above)
                side_full = NAU_RS_W'(NAU_ONE) + rs_l;
            else
                side_full = NAU_RS_W'(front.x);
        end
        c2_next.action = front.action;
        c2_next.last   = front.last;
        c2_next.neg    = front.neg;
        c2_next.sat    = front.sat;
        c2_next.side   = side_full[NAU_SIDE_W-1:0];
        f2_next        = pos[FRAC_W-1:0];
    end

    always_comb
    begin
        down3_next  = hi2_reg < lo2_reg;
        diff_full   = down3_next ? lo2_reg - hi2_reg : hi2_reg - lo2_reg;
        diff        = diff_full[DIFF_W-1:0];
        iprod3_next = IPROD_W'(diff) * IPROD_W'(f2_reg);
    end

    always_comb
    begin
        step            = iprod3_reg[IPROD_W-1:FRAC_W];
        val             = down3_reg ? lo3_reg - ENT_W'(step) : lo3_reg + ENT_W'(step);
        rsum            = (ENT_W + 1)'(val) + ((ENT_W + 1)'(1) << (RND_SH - 1));
        mid_next.action = c3_reg.action;
        mid_next.last   = c3_reg.last;
        mid_next.neg    = c3_reg.neg;
        mid_next.side   = c3_reg.side;
        mid_next.t      = c3_reg.sat ? NAU_T_W'(NAU_ONE) : rsum[RND_SH+NAU_T_W-1:RND_SH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            c2_reg  <= c2_next;
            f2_reg  <= f2_next;
            lo2_reg <= (mode == MODE_TANH) ? TANH_ROM[idx] : SIG_ROM[idx];
            hi2_reg <= (mode == MODE_TANH) ? TANH_ROM[idx_hi] : SIG_ROM[idx_hi];
        end
        if (en3)
        begin
            c3_reg     <= c2_reg;
            lo3_reg    <= lo2_reg;
            down3_reg  <= down3_next;
            iprod3_reg <= iprod3_next;
        end
        if (en4)
            mid_reg <= mid_next;
    end

endmodule

// ===== src/nau_finish.sv =====
// ----------------------------------------------------------------------------
// nau_finish
// Last stage: symmetry, leak scaling of negative tanh values, saturation to
// the output word.
// ----------------------------------------------------------------------------
module nau_finish (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [nau_pkg::NAU_MODE_W-1:0]        mode,
    input  logic                                  mid_valid,
    output logic                                  mid_ready,
    input  nau_pkg::mid_t                         mid,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [nau_pkg::NAU_DATA_W-1:0] result,
    output logic                                  last_out
);
    import nau_pkg::*;

    localparam logic signed [NAU_RS_W-1:0] MAX_OUT = NAU_RS_W'((1 << (NAU_DATA_W - 1)) - 1);
    localparam logic signed [NAU_RS_W-1:0] MIN_OUT = -NAU_RS_W'(1 << (NAU_DATA_W - 1));

    logic                          valid_reg;
    logic                          valid_next;
    logic                          en;
    logic signed [NAU_RS_W-1:0]    t_ext;
    logic signed [NAU_RS_W-1:0]    side_ext;
    logic signed [NAU_RS_W-1:0]    leak_in;
    logic signed [NAU_RS_W-1:0]    leak_out;
    logic signed [NAU_RS_W-1:0]    pre;
    logic signed [NAU_DATA_W-1:0]  result_reg, result_next;
    logic                          last_reg;

    assign en           = !valid_reg || result_ready;
    assign mid_ready    = en;
    assign valid_next   = en ? mid_valid : valid_reg;
    assign result_valid = valid_reg;
    assign result       = result_reg;
    assign last_out     = last_reg;

    always_comb
    begin
        t_ext    = $signed(NAU_RS_W'(mid.t));
        side_ext = NAU_RS_W'(mid.side);
        leak_in  = (mid.action == ACT_FORWARD) ? -t_ext : side_ext;
        leak_out = round_shift(leak_in * NAU_RS_W'(NAU_LEAK_NUM), NAU_LEAK_SHIFT);
        pre      = side_ext;
        if (mid.action == ACT_FORWARD)
        begin
            unique case (mode)
                MODE_SIGMOID: pre = mid.neg ? NAU_RS_W'(NAU_ONE) - t_ext : t_ext;
                MODE_TANH:    pre = mid.neg ? leak_out : t_ext;
                default:      pre = side_ext;
            endcase
        end
        else if (mode == MODE_TANH)
            pre = mid.neg ? leak_out : side_ext;
        priority if (pre > MAX_OUT)
            result_next = MAX_OUT[NAU_DATA_W-1:0];
        else if (pre < MIN_OUT)
            result_next = MIN_OUT[NAU_DATA_W-1:0];
        else
            result_next = pre[NAU_DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            last_reg   <= mid.last;
        end
    end

endmodule

// ===== bench/tb_neural_activation_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_neural_activation_unit
// Streams Q4.12 samples through the activation unit in every mode, with both
// forward and derivative actions, under random input gaps and output stalls.
// A bit-exact model of the table lookup, interpolation and fixed-point
// rounding predicts each result and the scoreboard compares them in order.
// ----------------------------------------------------------------------------
module tb_neural_activation_unit;
    import nau_pkg::*;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 20;
    localparam int MAX_REPORTS     = 50;
    localparam int GRID            = 8 * NAU_ONE / NAU_TABLE_ENTRIES;
    localparam int SAT_HI          = (1 << (NAU_DATA_W - 1)) - 1;
    localparam int SAT_LO          = -(1 << (NAU_DATA_W - 1));
    localparam bit [63:0] Q30      = 64'd1 << 30;

    localparam logic [NAU_ADDR_W-1:0] MODE_ADDR = NAU_ADDR_W'(4 * int'(NAU_REG_MODE));

    localparam mode_t PHASE_MODE [NUM_PHASES] =
        '{MODE_SIGMOID, MODE_RELU, MODE_TANH, MODE_SIGMOID, MODE_TANH, MODE_RELU};
    localparam int SEND_IDLE  [4] = '{0, 56, 0, 15};
    localparam int RECV_STALL [4] = '{0, 0, 56, 15};
    localparam logic signed [NAU_DATA_W-1:0] DIRECTED [8] =
        '{NAU_DATA_W'(-32768), NAU_DATA_W'(32767), NAU_DATA_W'(0), NAU_DATA_W'(1),
          NAU_DATA_W'(-1), NAU_DATA_W'(NAU_ONE), NAU_DATA_W'(NAU_ONE + 1),
          NAU_DATA_W'(-NAU_ONE)};

    typedef struct {
        logic signed [NAU_DATA_W-1:0] value;
        logic                         last;
    } activation_word_t;

    class activation_scoreboard;
        mode_t            mode;
        bit [31:0]        sig_rom  [NAU_TABLE_ENTRIES + 1];
        bit [31:0]        tanh_rom [NAU_TABLE_ENTRIES + 1];
        activation_word_t awaited [$];
        int               mismatches;
        int               checked;
        int               tally [3][2];

        function new();
            bit [63:0] t;
            bit [63:0] term;
            bit [63:0] e;
            bit [63:0] e2;
            longint    sum;
            mode = MODE_SIGMOID;
            for (int k = 0; k <= NAU_TABLE_ENTRIES; k++)
            begin
                t    = (64'(k) << 25) / NAU_TABLE_ENTRIES;
                sum  = longint'(Q30);
                term = Q30;
                for (int i = 1; i <= 6; i++)
                begin
                    term = q30_mul(term, t) / 64'(i);
                    if (i % 2 == 1)
                        sum -= longint'(term);
                    else
                        sum += longint'(term);
                end
                e = sum;
                repeat (8) e = q30_mul(e, e);
                e2 = q30_mul(e, e);
                sig_rom[k]  = 32'(((64'd1 << 60) + ((Q30 + e) >> 1)) / (Q30 + e));
                tanh_rom[k] = 32'(((Q30 - e2) << 30) / (Q30 + e2));
            end
        endfunction

        function bit [63:0] q30_mul(bit [63:0] a, bit [63:0] b);
            return (a * b + (64'd1 << 29)) >> 30;
        endfunction

        function longint round_half_away(longint p, int s);
            bit [63:0] m;
            m = (p < 0) ? -p : p;
            m = (m + (64'd1 << (s - 1))) >> s;
            return (p < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint leak(longint v);
            return round_half_away(v * NAU_LEAK_NUM, NAU_LEAK_SHIFT);
        endfunction

        function longint table_lookup(bit use_tanh, longint a);
            bit [63:0] p;
            bit [63:0] idx;
            bit [63:0] f;
            bit [63:0] lo;
            bit [63:0] hi;
            bit [63:0] v;
            if (a >= 8 * NAU_ONE)
                return NAU_ONE;
            p   = 64'(a) * NAU_TABLE_ENTRIES;
            idx = p >> NAU_MAG_W;
            f   = p & ((64'd1 << NAU_MAG_W) - 1);
            lo  = use_tanh ? tanh_rom[idx] : sig_rom[idx];
            hi  = use_tanh ? tanh_rom[idx + 1] : sig_rom[idx + 1];
            if (hi >= lo)
                v = lo + (((hi - lo) * f) >> NAU_MAG_W);
            else
                v = lo - (((lo - hi) * f) >> NAU_MAG_W);
            return longint'((v + (64'd1 << (29 - NAU_FRAC_BITS))) >> (30 - NAU_FRAC_BITS));
        endfunction

        function longint forward(longint x);
            longint t;
            case (mode)
                MODE_SIGMOID:
                begin
                    t = table_lookup(1'b0, (x < 0) ? -x : x);
                    return (x < 0) ? NAU_ONE - t : t;
                end
                MODE_RELU:
                begin
                    if (x < 0)
                        return leak(x);
                    if (x > NAU_ONE)
                        return NAU_ONE + leak(x - NAU_ONE);
                    return x;
                end
                MODE_TANH:
                begin
                    t = table_lookup(1'b1, (x < 0) ? -x : x);
                    return (x < 0) ? leak(-t) : t;
                end
                default: return 0;
            endcase
        endfunction

        function longint derivative(longint y);
            longint d;
            case (mode)
                MODE_SIGMOID: return round_half_away(y * (NAU_ONE - y), NAU_FRAC_BITS);
                MODE_RELU:    return (y < 0 || y > NAU_ONE) ? leak(NAU_ONE) : NAU_ONE;
                MODE_TANH:
                begin
                    d = NAU_ONE - round_half_away(y * y, NAU_FRAC_BITS);
                    return (y < 0) ? leak(d) : d;
                end
                default: return 0;
            endcase
        endfunction

        function logic signed [NAU_DATA_W-1:0] activation_of(logic act,
                                                             logic signed [NAU_DATA_W-1:0] v);
            longint r;
            r = (act == ACT_DERIV) ? derivative(longint'(v)) : forward(longint'(v));
            if (r > SAT_HI)
                r = SAT_HI;
            if (r < SAT_LO)
                r = SAT_LO;
            return NAU_DATA_W'(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s", $time, msg);
        endfunction

        function void note_sample(logic act, logic signed [NAU_DATA_W-1:0] v, logic lst);
            activation_word_t w;
            w.value = activation_of(act, v);
            w.last  = lst;
            awaited.push_back(w);
            tally[int'(mode)][act]++;
        endfunction

        function void check_result(logic signed [NAU_DATA_W-1:0] res, logic lst);
            activation_word_t w;
            if (awaited.size() == 0)
            begin
                flag($sformatf("result: expected none, actual %0d", res));
                return;
            end
            w = awaited.pop_front();
            checked++;
            if (res !== w.value)
                flag($sformatf("result: expected %0d, actual %0d", w.value, res));
            if (lst !== w.last)
                flag($sformatf("last_out: expected %0b, actual %0b", w.last, lst));
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [NAU_ADDR_W-1:0]        paddr;
    logic [NAU_PDATA_W-1:0]       pwdata;
    logic [NAU_PDATA_W-1:0]       prdata;
    logic                         pready;
    logic                         sample_valid;
    logic                         sample_ready;
    logic                         action;
    logic signed [NAU_DATA_W-1:0] value;
    logic                         last;
    logic                         result_valid;
    logic                         result_ready;
    logic signed [NAU_DATA_W-1:0] result;
    logic                         last_out;

    activation_scoreboard sb;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    bit                   long_hold;
    bit                   hold_done;
    int                   stuck_cycles = 0;
    int                   mode_writes  = 0;

    neural_activation_unit i_dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [NAU_DATA_W-1:0] pick_sample();
        int base;
        case ($urandom_range(5))
            0, 1: return NAU_DATA_W'($urandom);
            2:    return NAU_DATA_W'(int'($urandom_range(10 * NAU_ONE)) - 5 * NAU_ONE);
            3:    return NAU_DATA_W'(GRID * (int'($urandom_range(511)) - 256)
                                     + int'($urandom_range(2)) - 1);
            4:
            begin
                case ($urandom_range(3))
                    0:       base = 0;
                    1:       base = NAU_ONE;
                    2:       base = -NAU_ONE;
                    default: base = 8 * NAU_ONE;
                endcase
                return NAU_DATA_W'(base + int'($urandom_range(6)) - 3);
            end
            default: return NAU_DATA_W'($urandom_range(NAU_ONE));
        endcase
    endfunction

    task automatic send_sample(input logic act, input logic signed [NAU_DATA_W-1:0] v,
                               input logic lst);
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        sample_valid <= 1'b1;
        action       <= act;
        value        <= v;
        last         <= lst;
        do @(posedge clk); while (!sample_ready);
        sb.note_sample(act, v, lst);
    endtask

    // drop valid and wait for every pending result
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
    endtask

    task automatic mode_reg_access(input logic wr, input logic [NAU_PDATA_W-1:0] wdata,
                                   output logic [NAU_PDATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODE_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic verify_mode(input mode_t m);
        logic [NAU_PDATA_W-1:0] rd;
        mode_reg_access(1'b0, '0, rd);
        if (rd !== NAU_PDATA_W'(m))
            sb.flag($sformatf("mode readback: expected %0d, actual %0d", m, rd));
    endtask

    task automatic program_mode(input mode_t m);
        logic [NAU_PDATA_W-1:0] rd;
        mode_reg_access(1'b1, NAU_PDATA_W'(m), rd);
        sb.mode = m;
        mode_writes++;
        verify_mode(m);
    endtask

    // hold the output off while the sender keeps pushing
    initial
    begin
        result_ready = 1'b0;
        hold_done    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result, last_out);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved in %0d cycles", $time, WATCHDOG_LIMIT);
            $display("neural_activation_unit test failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        sample_valid   = 1'b0;
        action         = ACT_FORWARD;
        value          = '0;
        last           = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        verify_mode(MODE_SIGMOID);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
                program_mode(PHASE_MODE[ph]);
            send_idle_pct  = SEND_IDLE[ph % 4];
            recv_stall_pct = RECV_STALL[ph % 4];
            if (ph < 3)
                for (int i = 0; i < 8; i++)
                    send_sample(((i + ph) % 2) ? ACT_DERIV : ACT_FORWARD, DIRECTED[i], i == 7);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (ph == 0 && i == 100)
                    long_hold = 1'b1;
                if (ph == 3 && i == 125)
                    drain_results();
                send_sample($urandom_range(1) ? ACT_DERIV : ACT_FORWARD, pick_sample(),
                            $urandom_range(7) == 0);
            end
            drain_results();
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d results, fwd/der sigmoid %0d/%0d relu %0d/%0d tanh %0d/%0d",
                 sb.checked, sb.tally[0][0], sb.tally[0][1],
                 sb.tally[1][0], sb.tally[1][1], sb.tally[2][0], sb.tally[2][1]);
        $display("over %0d mode writes, input gaps, output stalls, a %0d-cycle output hold",
                 mode_writes, HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("neural_activation_unit test passed");
        else
            $display("neural_activation_unit test failed");
        $finish;
    end

endmodule
